### rtl/per_core_call_trace_profiler_core_defines.svh
// ----------------------------------------------------------------------------
// Call trace profiler assertion macros
// Shared assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef PER_CORE_CALL_TRACE_PROFILER_CORE_DEFINES_SVH
`define PER_CORE_CALL_TRACE_PROFILER_CORE_DEFINES_SVH

// invariant, checked on every clock
`define CPR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication
`define CPR_ASSERT_IMPLY(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

### rtl/cpr_pkg.sv
// ----------------------------------------------------------------------------
// Call trace profiler package
// Sizes, status codes and controller states.
// ----------------------------------------------------------------------------
package cpr_pkg;

  localparam int CORES         = 4;
  localparam int STACK_DEPTH   = 64;
  localparam int TABLE_ENTRIES = 256;

  localparam int CIDX_W = (CORES > 1) ? $clog2(CORES) : 1;
  localparam int SA_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int TAB_AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int STK_AW = CIDX_W + SA_W;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_BUMP     = 3'd1,
    ST_MATCH    = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_SFULL    = 3'd5,
    ST_TFULL    = 3'd6,
    ST_READ     = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_POP,
    S_SRCH,
    S_UPD,
    S_OUT
  } state_t;

endpackage

### rtl/per_core_call_trace_profiler_core.sv
// ----------------------------------------------------------------------------
// Per-core call trace profiler
// Per-core call stacks and a function table held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Input channel in_*: one transfer per trace event or table read. in_op 0 is a
// trace event (in_is_entry, in_core, in_func_addr, in_stamp); in_op 1 reads
// the table slot in_entry_index. Result channel out_*: exactly one transfer
// per input transfer, in order.
// Path to the result register: a read of a used slot passes S_DISP and S_UPD,
// any other read and an exit on an empty stack pass S_DISP only, and a
// mismatched exit passes S_DISP and S_POP. An entry scans the used table slots
// one per cycle through the function RAM read port in S_SRCH, then goes to
// S_UPD when the function is found and straight to S_OUT when it is absent.
// A matched exit passes S_POP for the stack pop before the same scan.
// in_rdy is high only while the controller is idle, in the cycle after the result
// register loads; it may accept the next transfer while a result still waits
// in the output register.
// If the receiver stalls, the finished result waits in the controller until
// the output register drains.
// Reset clears the stack pointers and the table fill level; RAM contents are
// not cleared, slots at or above the fill level read as unused.
// ----------------------------------------------------------------------------
`include "per_core_call_trace_profiler_core_defines.svh"

module per_core_call_trace_profiler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  output logic        in_rdy,
  input  logic        in_op,
  input  logic        in_is_entry,
  input  logic [1:0]  in_core,
  input  logic [63:0] in_func_addr,
  input  logic [63:0] in_stamp,
  input  logic [7:0]  in_entry_index,
  output logic        out_vld,
  input  logic        out_rdy,
  output logic [2:0]  out_status,
  output logic [63:0] out_func,
  output logic [31:0] out_count,
  output logic [63:0] out_total,
  output logic [6:0]  out_depth,
  output logic        out_valid
);

  localparam int CIDX_W = cpr_pkg::CIDX_W;
  localparam int SA_W   = cpr_pkg::SA_W;
  localparam int SP_W   = cpr_pkg::SP_W;
  localparam int TAB_AW = cpr_pkg::TAB_AW;
  localparam int FILL_W = cpr_pkg::FILL_W;
  localparam int STK_AW = cpr_pkg::STK_AW;

  cpr_pkg::state_t state_r, state_nxt;

  logic              op_r, entry_r;
  logic [1:0]        core_r;
  logic [63:0]       fn_r, stamp_r, pst_r;
  logic [7:0]        idx_r;
  logic [SP_W-1:0]   sp_r [cpr_pkg::CORES];
  logic [FILL_W-1:0] fill_r, cnt_r;
  logic              chk_r, sfull_r;
  logic [TAB_AW-1:0] slot_r;

  cpr_pkg::status_t  res_status_r;
  logic [63:0]       res_func_r, res_total_r;
  logic [31:0]       res_count_r;
  logic              res_valid_r;

  logic              out_vld_r;
  logic [2:0]        out_status_r;
  logic [63:0]       out_func_r, out_total_r;
  logic [31:0]       out_count_r;
  logic [6:0]        out_depth_r;
  logic              out_valid_r;

  logic                stk_we;
  logic [STK_AW-1:0]   stk_waddr, stk_raddr;
  logic [127:0]        stk_wdata, stk_rdata;
  logic                ft_we;
  logic [TAB_AW-1:0]   ft_waddr, ft_raddr;
  logic [63:0]         ft_wdata, ft_rdata;
  logic                dt_we;
  logic [TAB_AW-1:0]   dt_waddr, dt_raddr;
  logic [95:0]         dt_wdata, dt_rdata;

  logic [CIDX_W-1:0] cidx;
  logic [SP_W-1:0]   sp_cur;
  logic              core_ok, idx_ok, sp_full, sp_zero;
  logic              hit, miss_end, can_ins, out_free;
  logic [31:0]       upd_count;
  logic [63:0]       upd_time;

  assign cidx     = CIDX_W'(core_r);
  assign sp_cur   = sp_r[cidx];
  assign core_ok  = 32'(core_r) < cpr_pkg::CORES;
  assign idx_ok   = 32'(idx_r) < 32'(fill_r);
  assign sp_full  = sp_cur == SP_W'(cpr_pkg::STACK_DEPTH);
  assign sp_zero  = sp_cur == '0;
  assign hit      = chk_r && (ft_rdata == fn_r);
  assign miss_end = !hit && (cnt_r == fill_r);
  assign can_ins  = 32'(fill_r) < cpr_pkg::TABLE_ENTRIES;
  assign out_free = !out_vld_r || out_rdy;
  assign upd_count = dt_rdata[95:64] + 32'd1;
  assign upd_time  = dt_rdata[63:0] + (stamp_r - pst_r);

  cpr_ram #(.W(128), .AW(STK_AW)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );
  cpr_ram #(.W(64), .AW(TAB_AW)) u_ftab (
    .clk(clk), .we(ft_we), .waddr(ft_waddr), .wdata(ft_wdata),
    .raddr(ft_raddr), .rdata(ft_rdata)
  );
  cpr_ram #(.W(96), .AW(TAB_AW)) u_dtab (
    .clk(clk), .we(dt_we), .waddr(dt_waddr), .wdata(dt_wdata),
    .raddr(dt_raddr), .rdata(dt_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cpr_pkg::S_IDLE: if (in_vld) state_nxt = cpr_pkg::S_DISP;
      cpr_pkg::S_DISP: begin
        if (op_r) begin
          state_nxt = idx_ok ? cpr_pkg::S_UPD : cpr_pkg::S_OUT;
        end else if (!core_ok) begin
          state_nxt = cpr_pkg::S_OUT;
        end else if (entry_r) begin
          state_nxt = cpr_pkg::S_SRCH;
        end else begin
          state_nxt = sp_zero ? cpr_pkg::S_OUT : cpr_pkg::S_POP;
        end
      end
      cpr_pkg::S_POP: begin
        state_nxt = (stk_rdata[127:64] == fn_r) ? cpr_pkg::S_SRCH : cpr_pkg::S_OUT;
      end
      cpr_pkg::S_SRCH: begin
        if (hit) begin
          state_nxt = cpr_pkg::S_UPD;
        end else if (miss_end) begin
          state_nxt = cpr_pkg::S_OUT;
        end
      end
      cpr_pkg::S_UPD: state_nxt = cpr_pkg::S_OUT;
      cpr_pkg::S_OUT: if (out_free) state_nxt = cpr_pkg::S_IDLE;
      default: state_nxt = cpr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_rdy    = state_r == cpr_pkg::S_IDLE;
    stk_we    = 1'b0;
    stk_waddr = {cidx, SA_W'(sp_cur)};
    stk_wdata = {fn_r, stamp_r};
    stk_raddr = {cidx, SA_W'(sp_cur - SP_W'(1))};
    ft_we     = 1'b0;
    ft_waddr  = TAB_AW'(fill_r);
    ft_wdata  = fn_r;
    ft_raddr  = TAB_AW'(cnt_r);
    dt_we     = 1'b0;
    dt_waddr  = TAB_AW'(fill_r);
    dt_wdata  = {32'd1, 64'd0};
    dt_raddr  = TAB_AW'(cnt_r - FILL_W'(1));
    unique case (state_r)
      cpr_pkg::S_DISP: begin
        ft_raddr = TAB_AW'(idx_r);
        dt_raddr = TAB_AW'(idx_r);
        stk_we   = !op_r && core_ok && entry_r && !sp_full;
      end
      cpr_pkg::S_SRCH: begin
        ft_we = miss_end && entry_r && can_ins;
        dt_we = miss_end && entry_r && can_ins;
      end
      cpr_pkg::S_UPD: begin
        dt_waddr = slot_r;
        dt_we    = !op_r;
        dt_wdata = entry_r ? {upd_count, dt_rdata[63:0]} : {dt_rdata[95:64], upd_time};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cpr_pkg::S_IDLE;
      fill_r    <= '0;
      out_vld_r <= 1'b0;
      chk_r     <= 1'b0;
      core_r    <= '0;
      for (int i = 0; i < cpr_pkg::CORES; i++) begin
        sp_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= ((state_r == cpr_pkg::S_OUT) && out_free) || (out_vld_r && !out_rdy);
      unique case (state_r)
        cpr_pkg::S_IDLE: begin
          op_r    <= in_op;
          entry_r <= in_is_entry;
          core_r  <= in_core;
          fn_r    <= in_func_addr;
          stamp_r <= in_stamp;
          idx_r   <= in_entry_index;
        end
        cpr_pkg::S_DISP: begin
          cnt_r        <= '0;
          chk_r        <= 1'b0;
          sfull_r      <= sp_full;
          slot_r       <= TAB_AW'(idx_r);
          res_count_r  <= '0;
          res_total_r  <= '0;
          res_valid_r  <= 1'b0;
          if (op_r) begin
            res_func_r   <= '0;
            res_status_r <= cpr_pkg::ST_READ;
          end else begin
            res_func_r   <= fn_r;
            res_status_r <= cpr_pkg::ST_EMPTY;
            if (core_ok && entry_r && !sp_full) begin
              sp_r[cidx] <= sp_cur + SP_W'(1);
            end else if (core_ok && !entry_r && !sp_zero) begin
              sp_r[cidx] <= sp_cur - SP_W'(1);
            end
          end
        end
        cpr_pkg::S_POP: begin
          pst_r        <= stk_rdata[63:0];
          res_func_r   <= stk_rdata[127:64];
          res_status_r <= cpr_pkg::ST_MISMATCH;
        end
        cpr_pkg::S_SRCH: begin
          if (hit) begin
            slot_r <= TAB_AW'(cnt_r - FILL_W'(1));
          end else if (miss_end) begin
            if (!entry_r) begin
              res_status_r <= cpr_pkg::ST_MATCH;
            end else if (can_ins) begin
              fill_r       <= fill_r + FILL_W'(1);
              res_count_r  <= 32'd1;
              res_valid_r  <= 1'b1;
              res_status_r <= sfull_r ? cpr_pkg::ST_SFULL : cpr_pkg::ST_NEW;
            end else begin
              res_status_r <= cpr_pkg::ST_TFULL;
            end
          end else begin
            cnt_r <= cnt_r + FILL_W'(1);
            chk_r <= 1'b1;
          end
        end
        cpr_pkg::S_UPD: begin
          res_valid_r <= 1'b1;
          res_func_r  <= op_r ? ft_rdata : fn_r;
          res_count_r <= (!op_r && entry_r) ? upd_count : dt_rdata[95:64];
          res_total_r <= (!op_r && !entry_r) ? upd_time : dt_rdata[63:0];
          if (op_r) begin
            res_status_r <= cpr_pkg::ST_READ;
          end else if (entry_r) begin
            res_status_r <= sfull_r ? cpr_pkg::ST_SFULL : cpr_pkg::ST_BUMP;
          end else begin
            res_status_r <= cpr_pkg::ST_MATCH;
          end
        end
        cpr_pkg::S_OUT: begin
          if (out_free) begin
            out_status_r <= res_status_r;
            out_func_r   <= res_func_r;
            out_count_r  <= res_count_r;
            out_total_r  <= res_total_r;
            out_valid_r  <= res_valid_r;
            out_depth_r  <= core_ok ? 7'(sp_cur) : 7'd0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_vld    = out_vld_r;
  assign out_status = out_status_r;
  assign out_func   = out_func_r;
  assign out_count  = out_count_r;
  assign out_total  = out_total_r;
  assign out_depth  = out_depth_r;
  assign out_valid  = out_valid_r;

  `CPR_ASSERT_ALWAYS(a_fill_bound, 32'(fill_r) <= cpr_pkg::TABLE_ENTRIES, "fill over size")
  `CPR_ASSERT_IMPLY(a_scan_bound, state_r == cpr_pkg::S_SRCH, cnt_r <= fill_r, "scan past fill")
  `CPR_ASSERT_IMPLY(a_fill_mono, $past(rst_n), fill_r >= $past(fill_r), "fill decreased")
  `CPR_ASSERT_IMPLY(a_sp_bound, 1'b1, sp_cur <= SP_W'(cpr_pkg::STACK_DEPTH), "stack overrun")

endmodule

### rtl/cpr_ram.sv
// ----------------------------------------------------------------------------
// Call trace profiler RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
module cpr_ram #(
  parameter int W  = 64,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
